[sv/three_wire_spi_master_top_assert.svh]
// Assertion macros used by the serial master datapath
`ifndef THREE_WIRE_SPI_MASTER_TOP_ASSERT_SVH
`define THREE_WIRE_SPI_MASTER_TOP_ASSERT_SVH

// Same-cycle implication
`define TWSM_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define TWSM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/twsm_pkg.sv]
package twsm_pkg;

  localparam int unsigned HALF_W    = 16;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned SHIFT_W   = 16;
  localparam int unsigned COUNT_W   = 5;
  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned OUT_DATA_W = 32;

  localparam logic [HALF_W-1:0] HALF_RESET  = 16'd5;
  localparam logic [BYTE_W-1:0] READ_FLAG   = 8'h40;
  localparam logic [COUNT_W-1:0] BITS_REG   = 5'd16;
  localparam logic [COUNT_W-1:0] BITS_BYTE  = 5'd8;
  localparam logic [COUNT_W-1:0] BITS_NONE  = 5'd0;

  typedef enum logic [1:0] {
    CMD_WRITE_REG = 2'd0,
    CMD_READ_REG  = 2'd1,
    CMD_SEND_BYTE = 2'd2,
    CMD_READ_BYTE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_LOW  = 2'd1,
    ST_HIGH = 2'd2,
    ST_DONE = 2'd3
  } state_t;

  typedef struct packed {
    logic load;
    logic run;
    logic sample;
    logic advance;
    logic finish;
  } ctl_t;

  typedef struct packed {
    logic div_done;
    logic last_bit;
    logic out_busy;
  } status_t;

endpackage

[sv/three_wire_spi_master_top.sv]
// Each word is shifted out and in as N serial bits, where N is
// 16 for register commands and 8 for byte commands; half period H (0 acts as 1) sets bit speed.
// A new word is taken only while idle, once the last result has entered the output register.
// A finished result waits in the output register while the next word starts.
// rst (synchronous, active high) idles the engine, releases select, drops tvalid
// and restores the half period to 5.
module three_wire_spi_master_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [twsm_pkg::HALF_W-1:0]      cfg_wdata,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [twsm_pkg::IN_DATA_W-1:0]   s_axis_tdata,  // first_byte, write_data, line_bits
  input  logic                             s_axis_tlast,  // end_frame
  input  logic [1:0]                       s_axis_tuser,  // command
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [twsm_pkg::OUT_DATA_W-1:0]  m_axis_tdata,  // read_data, bits_driven, bit_total, zero pad
  output logic                             m_axis_tlast   // select_high
);

  twsm_pkg::ctl_t                       ctl;
  twsm_pkg::status_t                    status;
  logic [twsm_pkg::BYTE_W-1:0]          read_data;
  logic [twsm_pkg::SHIFT_W-1:0]         bits_driven;
  logic [twsm_pkg::COUNT_W-1:0]         bit_total;

  twsm_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (s_axis_tvalid),
    .status (status),
    .ready  (s_axis_tready),
    .ctl    (ctl)
  );

  twsm_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .ctl         (ctl),
    .command     (s_axis_tuser),
    .first_byte  (s_axis_tdata[7:0]),
    .write_data  (s_axis_tdata[15:8]),
    .end_frame   (s_axis_tlast),
    .line_bits   (s_axis_tdata[23:16]),
    .out_ready   (m_axis_tready),
    .status      (status),
    .out_valid   (m_axis_tvalid),
    .read_data   (read_data),
    .bits_driven (bits_driven),
    .bit_total   (bit_total),
    .select_high (m_axis_tlast)
  );

  assign m_axis_tdata = {3'b000, bit_total, bits_driven, read_data};

endmodule

[sv/twsm_ctrl.sv]
module twsm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  twsm_pkg::status_t status,
  output logic              ready,
  output twsm_pkg::ctl_t    ctl
);

  twsm_pkg::state_t state;
  twsm_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= twsm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      twsm_pkg::ST_IDLE: begin
        if (start) state_next = twsm_pkg::ST_LOW;
      end
      twsm_pkg::ST_LOW: begin
        if (status.div_done) state_next = twsm_pkg::ST_HIGH;
      end
      twsm_pkg::ST_HIGH: begin
        if (status.div_done) begin
          state_next = status.last_bit ? twsm_pkg::ST_DONE : twsm_pkg::ST_LOW;
        end
      end
      twsm_pkg::ST_DONE: begin
        if (!status.out_busy) state_next = twsm_pkg::ST_IDLE;
      end
      default: state_next = twsm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctl   = '0;
    ready = 1'b0;
    case (state)
      twsm_pkg::ST_IDLE: begin
        ready    = 1'b1;
        ctl.load = start;
      end
      twsm_pkg::ST_LOW: begin
        ctl.run    = 1'b1;
        ctl.sample = status.div_done;
      end
      twsm_pkg::ST_HIGH: begin
        ctl.run     = 1'b1;
        ctl.advance = status.div_done;
      end
      twsm_pkg::ST_DONE: begin
        ctl.finish = !status.out_busy;
      end
      default: begin
        ready = 1'b0;
      end
    endcase
  end

endmodule

[sv/twsm_datapath.sv]
`include "three_wire_spi_master_top_assert.svh"

module twsm_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [twsm_pkg::HALF_W-1:0]   cfg_wdata,
  input  twsm_pkg::ctl_t                ctl,
  input  logic [1:0]                    command,
  input  logic [twsm_pkg::BYTE_W-1:0]   first_byte,
  input  logic [twsm_pkg::BYTE_W-1:0]   write_data,
  input  logic                          end_frame,
  input  logic [twsm_pkg::BYTE_W-1:0]   line_bits,
  input  logic                          out_ready,
  output twsm_pkg::status_t             status,
  output logic                          out_valid,
  output logic [twsm_pkg::BYTE_W-1:0]   read_data,
  output logic [twsm_pkg::SHIFT_W-1:0]  bits_driven,
  output logic [twsm_pkg::COUNT_W-1:0]  bit_total,
  output logic                          select_high
);

  logic [twsm_pkg::HALF_W-1:0]  half_period;
  logic [twsm_pkg::HALF_W-1:0]  half_m1;
  logic [twsm_pkg::HALF_W-1:0]  div_cnt;
  twsm_pkg::cmd_t               cmd_r;
  logic                         end_r;
  logic [twsm_pkg::SHIFT_W-1:0] tx_shift;
  logic [twsm_pkg::BYTE_W-1:0]  line_shift;
  logic [twsm_pkg::BYTE_W-1:0]  rx_shift;
  logic [twsm_pkg::SHIFT_W-1:0] drv_acc;
  logic [twsm_pkg::COUNT_W-1:0] bit_cnt;
  logic [twsm_pkg::COUNT_W-1:0] total;
  logic [twsm_pkg::COUNT_W-1:0] n_drive;
  logic                         release_sel;
  logic                         select_active;
  logic                         sdio;
  twsm_pkg::cmd_t               cmd_in;
  logic [twsm_pkg::SHIFT_W-1:0] tx_load;

  assign cmd_in  = twsm_pkg::cmd_t'(command);
  assign half_m1 = (half_period == '0) ? '0 : half_period - 1'b1;
  assign sdio    = tx_shift[twsm_pkg::SHIFT_W-1];

  always_comb begin
    case (cmd_r)
      twsm_pkg::CMD_WRITE_REG: begin
        total = twsm_pkg::BITS_REG;  n_drive = twsm_pkg::BITS_REG;
      end
      twsm_pkg::CMD_READ_REG: begin
        total = twsm_pkg::BITS_REG;  n_drive = twsm_pkg::BITS_BYTE;
      end
      twsm_pkg::CMD_SEND_BYTE: begin
        total = twsm_pkg::BITS_BYTE; n_drive = twsm_pkg::BITS_BYTE;
      end
      default: begin
        total = twsm_pkg::BITS_BYTE; n_drive = twsm_pkg::BITS_NONE;
      end
    endcase
  end

  always_comb begin
    case (cmd_in)
      twsm_pkg::CMD_WRITE_REG: tx_load = {first_byte, write_data};
      twsm_pkg::CMD_READ_REG:  tx_load = {first_byte | twsm_pkg::READ_FLAG, 8'h00};
      twsm_pkg::CMD_SEND_BYTE: tx_load = {first_byte, 8'h00};
      default:                 tx_load = '0;
    endcase
  end

  assign release_sel = (cmd_r == twsm_pkg::CMD_WRITE_REG) ||
                       (cmd_r == twsm_pkg::CMD_READ_REG) || end_r;

  assign status.div_done = (div_cnt == half_m1);
  assign status.last_bit = (bit_cnt == total - 1'b1);
  assign status.out_busy = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_period <= twsm_pkg::HALF_RESET;
    end else if (cfg_we) begin
      half_period <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (ctl.load || !ctl.run || status.div_done) begin
      div_cnt <= '0;
    end else begin
      div_cnt <= div_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_cnt <= '0;
    end else if (ctl.load) begin
      bit_cnt <= '0;
    end else if (ctl.advance) begin
      bit_cnt <= bit_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r      <= cmd_in;
      end_r      <= end_frame;
      tx_shift   <= tx_load;
      line_shift <= line_bits;
      rx_shift   <= '0;
      drv_acc    <= '0;
    end else if (ctl.sample) begin
      if (bit_cnt < n_drive) begin
        drv_acc  <= {drv_acc[twsm_pkg::SHIFT_W-2:0], sdio};
        tx_shift <= {tx_shift[twsm_pkg::SHIFT_W-2:0], 1'b0};
      end else begin
        rx_shift   <= {rx_shift[twsm_pkg::BYTE_W-2:0], line_shift[twsm_pkg::BYTE_W-1]};
        line_shift <= {line_shift[twsm_pkg::BYTE_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      select_active <= 1'b0;
    end else if (ctl.load) begin
      select_active <= 1'b1;
    end else if (ctl.finish) begin
      select_active <= !release_sel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.finish) begin
      read_data   <= rx_shift;
      bits_driven <= drv_acc;
      bit_total   <= total;
      select_high <= release_sel;
    end
  end

  `TWSM_ASSERT_IMPL(a_finish_free, ctl.finish, !(out_valid && !out_ready), "result overwritten")
  `TWSM_ASSERT_NEXT(a_reg_release, ctl.finish && !cmd_r[1], !select_active, "select left low")
  `TWSM_ASSERT_IMPL(a_div_range, ctl.run, div_cnt <= half_m1, "divider overran phase")
  `TWSM_ASSERT_IMPL(a_bit_range, ctl.advance, bit_cnt < total, "bit count past end")

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;

  localparam int MAX_CYCLES  = 6_000_000;
  localparam int MAX_REPORTS = 40;

  typedef struct packed {
    logic [7:0]  read_data;
    logic [15:0] bits_driven;
    logic [4:0]  bit_total;
    logic        select_high;
  } bus_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tlast;

  bus_result_t pending_results[$];
  logic [15:0] half_period = twsm_pkg::HALF_RESET;
  int          errors = 0;
  int          items_sent = 0;
  int          cycles = 0;
  int          idle_send = 0;
  int          stall_recv = 0;

  three_wire_spi_master_top uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= MAX_CYCLES) begin
      $display("three_wire_spi_master_top regression: fail");
      $finish;
    end
  end

  function automatic logic [7:0] rand8();
    return 8'($urandom_range(255));
  endfunction

  function automatic bus_result_t predict_bus_result(twsm_pkg::cmd_t cmd, logic [7:0] first,
                                                     logic [7:0] wdata, logic [7:0] line,
                                                     logic endf);
    bus_result_t r;
    r = '{read_data: 8'h00, bits_driven: 16'h0000, bit_total: twsm_pkg::BITS_BYTE,
          select_high: 1'b1};
    case (cmd)
      twsm_pkg::CMD_WRITE_REG: begin
        r.bits_driven = {first, wdata};
        r.bit_total   = twsm_pkg::BITS_REG;
      end
      twsm_pkg::CMD_READ_REG: begin
        r.bits_driven = {8'h00, first | twsm_pkg::READ_FLAG};
        r.read_data   = line;
        r.bit_total   = twsm_pkg::BITS_REG;
      end
      twsm_pkg::CMD_SEND_BYTE: begin
        r.bits_driven = {8'h00, first};
        r.select_high = endf;
      end
      default: begin
        r.read_data   = line;
        r.select_high = endf;
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    if (errors < MAX_REPORTS)
      $display("mismatch at cycle %0d: %s got %0h expected %0h", cycles, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    bus_result_t got;
    bus_result_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= stall_recv);
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{m_axis_tdata[7:0], m_axis_tdata[23:8], m_axis_tdata[28:24], m_axis_tlast};
        if (m_axis_tdata[31:29] != 3'b000)
          report_mismatch("pad bits", m_axis_tdata[31:29], 0);
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected word", m_axis_tdata, 0);
        end else begin
          want = pending_results.pop_front();
          if (got.read_data != want.read_data)
            report_mismatch("read_data", got.read_data, want.read_data);
          if (got.bits_driven != want.bits_driven)
            report_mismatch("bits_driven", got.bits_driven, want.bits_driven);
          if (got.bit_total != want.bit_total)
            report_mismatch("bit_total", got.bit_total, want.bit_total);
          if (got.select_high != want.select_high)
            report_mismatch("select_high", got.select_high, want.select_high);
        end
      end
    end
  end

  task automatic send_word(twsm_pkg::cmd_t cmd, logic [7:0] first, logic [7:0] wdata,
                           logic [7:0] line, logic endf);
    if ($urandom_range(99) < idle_send) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= {rand8(), rand8(), rand8()};
      do @(posedge clk); while ($urandom_range(99) < idle_send);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {line, wdata, first};
    s_axis_tlast  <= endf;
    s_axis_tuser  <= cmd;
    do @(posedge clk); while (!s_axis_tready);
    pending_results.push_back(predict_bus_result(cmd, first, wdata, line, endf));
    items_sent++;
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic set_half_period(logic [15:0] value);
    wait_drained();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cfg_wdata <= 16'($urandom_range(16'hFFFF));
    half_period = value;
  endtask

  task automatic random_register();
    send_word($urandom_range(1) ? twsm_pkg::CMD_READ_REG : twsm_pkg::CMD_WRITE_REG,
              rand8(), rand8(), rand8(), 1'($urandom_range(1)));
  endtask

  task automatic random_frame();
    int len;
    len = $urandom_range(1, 6);
    send_word(twsm_pkg::CMD_SEND_BYTE, rand8(), rand8(), rand8(), len == 1);
    for (int i = 1; i < len; i++) begin
      if ($urandom_range(9) == 0) begin
        random_register();
        return;
      end
      send_word($urandom_range(1) ? twsm_pkg::CMD_READ_BYTE : twsm_pkg::CMD_SEND_BYTE,
                rand8(), rand8(), rand8(), i == len - 1);
    end
  endtask

  task automatic test_directed();
    send_word(twsm_pkg::CMD_READ_REG,  8'h00, 8'h00, 8'h00, 1'b0);
    send_word(twsm_pkg::CMD_WRITE_REG, 8'h00, 8'h00, 8'h00, 1'b0);
    send_word(twsm_pkg::CMD_WRITE_REG, 8'hFF, 8'hFF, 8'hFF, 1'b1);
    send_word(twsm_pkg::CMD_WRITE_REG, 8'h40, 8'h5A, 8'h00, 1'b0);
    send_word(twsm_pkg::CMD_WRITE_REG, 8'h3F, 8'hA5, 8'h00, 1'b0);
    send_word(twsm_pkg::CMD_READ_REG,  8'hFF, 8'h00, 8'hFF, 1'b1);
    send_word(twsm_pkg::CMD_READ_REG,  8'h3F, 8'hFF, 8'h81, 1'b0);
    send_word(twsm_pkg::CMD_READ_REG,  8'h40, 8'h00, 8'h7E, 1'b0);
    send_word(twsm_pkg::CMD_SEND_BYTE, 8'hFF, 8'h00, 8'h00, 1'b1);
    send_word(twsm_pkg::CMD_SEND_BYTE, 8'h00, 8'hFF, 8'hFF, 1'b1);
    send_word(twsm_pkg::CMD_READ_BYTE, 8'h00, 8'h00, 8'hFF, 1'b1);
    send_word(twsm_pkg::CMD_READ_BYTE, 8'hFF, 8'hFF, 8'h00, 1'b1);
    // burst: open frame, several bytes, close
    send_word(twsm_pkg::CMD_SEND_BYTE, 8'hC5, 8'h00, 8'h00, 1'b0);
    send_word(twsm_pkg::CMD_READ_BYTE, 8'h00, 8'h00, 8'hA5, 1'b0);
    send_word(twsm_pkg::CMD_SEND_BYTE, 8'h80, 8'h00, 8'h00, 1'b0);
    send_word(twsm_pkg::CMD_READ_BYTE, 8'h00, 8'h00, 8'h01, 1'b1);
    // register access inside an open frame closes it
    send_word(twsm_pkg::CMD_SEND_BYTE, 8'h01, 8'h00, 8'h00, 1'b0);
    send_word(twsm_pkg::CMD_WRITE_REG, 8'h12, 8'h34, 8'h00, 1'b0);
    send_word(twsm_pkg::CMD_READ_BYTE, 8'h00, 8'h00, 8'h55, 1'b0);
    send_word(twsm_pkg::CMD_READ_REG,  8'h01, 8'h00, 8'hAA, 1'b0);
    send_word(twsm_pkg::CMD_WRITE_REG, 8'h7F, 8'h80, 8'h00, 1'b1);
    wait_drained();
  endtask

  task automatic test_half_period_extremes();
    set_half_period(16'hFFFF);
    send_word(twsm_pkg::CMD_SEND_BYTE, rand8(), rand8(), rand8(), 1'b1);
    set_half_period(16'h0000);
    send_word(twsm_pkg::CMD_WRITE_REG, rand8(), rand8(), rand8(), 1'b0);
    send_word(twsm_pkg::CMD_READ_REG,  rand8(), rand8(), rand8(), 1'b0);
    send_word(twsm_pkg::CMD_SEND_BYTE, rand8(), rand8(), rand8(), 1'b0);
    send_word(twsm_pkg::CMD_READ_BYTE, rand8(), rand8(), rand8(), 1'b1);
    set_half_period(16'h0001);
    send_word(twsm_pkg::CMD_READ_REG,  rand8(), rand8(), rand8(), 1'b1);
    send_word(twsm_pkg::CMD_READ_BYTE, rand8(), rand8(), rand8(), 1'b0);
    send_word(twsm_pkg::CMD_SEND_BYTE, rand8(), rand8(), rand8(), 1'b1);
    wait_drained();
  endtask

  task automatic test_drain_pause();
    repeat (3) random_frame();
    wait_drained();
    repeat (3) random_register();
    wait_drained();
  endtask

  task automatic test_random(int count, logic [15:0] hp, int idle_pct, int stall_pct);
    int target;
    int pick;
    set_half_period(hp);
    idle_send  = idle_pct;
    stall_recv = stall_pct;
    target = items_sent + count;
    while (items_sent < target) begin
      pick = $urandom_range(99);
      if (pick < 35) random_register();
      else if (pick < 80) random_frame();
      else send_word(twsm_pkg::cmd_t'($urandom_range(3)), rand8(), rand8(), rand8(),
                     1'($urandom_range(1)));
    end
    wait_drained();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_half_period_extremes();
    test_random(260, 16'd5, 0, 0);
    test_random(260, 16'd1, 48, 0);
    test_drain_pause();
    test_random(260, 16'd2, 0, 48);
    test_random(260, 16'd3, 27, 27);

    wait_drained();
    repeat (2 + 2 * 16 * ((half_period == 0) ? 1 : int'(half_period)) + 20) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("three_wire_spi_master_top regression: pass");
    end else begin
      $display("three_wire_spi_master_top regression: fail");
    end
    $finish;
  end

endmodule
